// ----- hw/rtl/tlts_pkg.sv -----
// tlts_pkg: constants, codes and item types of the tidal level time step block
// used by every module under hw/rtl; depends on nothing
`timescale 1ns / 1ps
package tlts_pkg;

    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;

    localparam int NUM_TERMS  = 5;
    localparam int ASIN_STEPS = 31;

    localparam logic [1:0] CFG_RANGE  = 2'd0;
    localparam logic [1:0] CFG_PERIOD = 2'd1;
    localparam logic [1:0] CFG_STEP   = 2'd2;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_PERIOD = 2'd1;
    localparam logic [1:0] ERR_ZERO   = 2'd2;

    typedef struct packed {
        logic        err_period;
        logic        err_zero;
        logic [31:0] t0;
    } item_t;

    typedef struct packed {
        logic  neg;
        item_t item;
    } fold_t;

    typedef struct packed {
        logic               zneg;
        logic               waning;
        logic signed [24:0] z0;
        item_t              item;
    } lvl_t;

    function automatic logic [6:0] term_div(input int j);
        logic [6:0] k;
        case (j)
            0:       k = 7'd110;
            1:       k = 7'd72;
            2:       k = 7'd42;
            3:       k = 7'd20;
            default: k = 7'd6;
        endcase
        return k;
    endfunction

endpackage

// ----- hw/rtl/tlts_div.sv -----
// tlts_div: pipelined restoring divider, one quotient bit per stage
// uses tlts_pkg; numerator must not exceed the divisor
`timescale 1ns / 1ps
module tlts_div
    import tlts_pkg::*;
#(
    parameter int W    = 32,
    parameter int QW   = 33,
    parameter int SB_W = 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [W-1:0]    num,
    input  logic [W-1:0]    den,
    input  logic [SB_W-1:0] sb_in,
    output logic            out_valid,
    output logic [QW-1:0]   quo,
    output logic [SB_W-1:0] sb_out
);

    logic            v_reg  [0:QW-1];
    logic [W-1:0]    r_reg  [0:QW-1];
    logic [QW-1:0]   q_reg  [0:QW-1];
    logic [SB_W-1:0] sb_reg [0:QW-1];

    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_stage
            logic [W:0]    rs;
            logic          ge;
            logic [W-1:0]  r_next;
            logic [QW-1:0] q_next;
            logic          v_in;
            logic [SB_W-1:0] sb_in_i;

            if (i == 0)
            begin : g_first
                assign rs      = {1'b0, num};
                assign v_in    = in_valid;
                assign sb_in_i = sb_in;
                assign ge      = rs >= {1'b0, den};
                assign q_next  = QW'(ge);
            end
            else
            begin : g_rest
                assign rs      = {r_reg[i-1], 1'b0};
                assign v_in    = v_reg[i-1];
                assign sb_in_i = sb_reg[i-1];
                assign ge      = rs >= {1'b0, den};
                assign q_next  = {q_reg[i-1][QW-2:0], ge};
            end

            assign r_next = ge ? W'(rs - {1'b0, den}) : rs[W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[i] <= 1'b0;
                else if (en)
                    v_reg[i] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[i]  <= r_next;
                    q_reg[i]  <= q_next;
                    sb_reg[i] <= sb_in_i;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign sb_out    = sb_reg[QW-1];

endmodule

// ----- hw/rtl/tlts_sine.sv -----
// tlts_sine: pipelined quarter-wave sine, Q30 in and out, 18 stages
// uses tlts_pkg for the series constants
`timescale 1ns / 1ps
module tlts_sine
    import tlts_pkg::*;
#(
    parameter int SB_W = 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [30:0]     f,
    input  logic [SB_W-1:0] sb_in,
    output logic            out_valid,
    output logic [30:0]     s,
    output logic [SB_W-1:0] sb_out
);

    logic            v0_reg, v1_reg, vf_reg;
    logic [30:0]     a0_reg, a1_reg;
    logic [31:0]     x1_reg;
    logic [SB_W-1:0] sb0_reg, sb1_reg, sbf_reg;
    logic [30:0]     s_reg;

    logic [30:0] fc;
    logic [63:0] a_prod, x_prod, s_prod;
    logic [31:0] s_raw;

    logic            tv  [0:NUM_TERMS];
    logic [30:0]     ta  [0:NUM_TERMS];
    logic [31:0]     tx  [0:NUM_TERMS];
    logic [30:0]     tt  [0:NUM_TERMS];
    logic [SB_W-1:0] tsb [0:NUM_TERMS];

    assign fc     = (f > ONE_Q30) ? ONE_Q30 : f;
    assign a_prod = 64'(fc) * 64'(PI_HALF_Q30);
    assign x_prod = 64'(a0_reg) * 64'(a0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            vf_reg <= tv[NUM_TERMS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg  <= a_prod[60:30];
            sb0_reg <= sb_in;
            a1_reg  <= a0_reg;
            x1_reg  <= x_prod[61:30];
            sb1_reg <= sb0_reg;
            s_reg   <= (s_raw > 32'(ONE_Q30)) ? ONE_Q30 : s_raw[30:0];
            sbf_reg <= tsb[NUM_TERMS];
        end
    end

    assign tv[0]  = v1_reg;
    assign ta[0]  = a1_reg;
    assign tx[0]  = x1_reg;
    assign tt[0]  = ONE_Q30;
    assign tsb[0] = sb1_reg;

    genvar j;
    generate
        for (j = 0; j < NUM_TERMS; j++)
        begin : g_term
            localparam logic [6:0]  KDIV  = term_div(j);
            localparam logic [29:0] RECIP = 30'((64'd1 << 32) / 64'(KDIV));

            logic            pv_reg, qv_reg, cv_reg;
            logic [31:0]     pp_reg, qp_reg;
            logic [29:0]     qe_reg;
            logic [30:0]     pa_reg, qa_reg, ca_reg, ct_reg;
            logic [31:0]     px_reg, qx_reg, cx_reg;
            logic [SB_W-1:0] psb_reg, qsb_reg, csb_reg;

            logic [63:0] p_prod, q_prod;
            logic [36:0] qk, rem;
            logic        ge;
            logic [30:0] q_fix, t_next;

            assign p_prod = 64'(tx[j]) * 64'(tt[j]);
            assign q_prod = 64'(pp_reg) * 64'(RECIP);
            assign qk     = 37'(qe_reg) * 37'(KDIV);
            assign rem    = 37'(qp_reg) - qk;
            assign ge     = rem >= 37'(KDIV);
            assign q_fix  = 31'(qe_reg) + 31'(ge);
            assign t_next = ONE_Q30 - q_fix;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    pv_reg <= 1'b0;
                    qv_reg <= 1'b0;
                    cv_reg <= 1'b0;
                end
                else if (en)
                begin
                    pv_reg <= tv[j];
                    qv_reg <= pv_reg;
                    cv_reg <= qv_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pp_reg  <= p_prod[61:30];
                    pa_reg  <= ta[j];
                    px_reg  <= tx[j];
                    psb_reg <= tsb[j];
                    qe_reg  <= q_prod[61:32];
                    qp_reg  <= pp_reg;
                    qa_reg  <= pa_reg;
                    qx_reg  <= px_reg;
                    qsb_reg <= psb_reg;
                    ct_reg  <= t_next;
                    ca_reg  <= qa_reg;
                    cx_reg  <= qx_reg;
                    csb_reg <= qsb_reg;
                end
            end

            assign tv[j+1]  = cv_reg;
            assign ta[j+1]  = ca_reg;
            assign tx[j+1]  = cx_reg;
            assign tt[j+1]  = ct_reg;
            assign tsb[j+1] = csb_reg;
        end
    endgenerate

    assign s_prod = 64'(ta[NUM_TERMS]) * 64'(tt[NUM_TERMS]);
    assign s_raw  = s_prod[61:30];

    assign out_valid = vf_reg;
    assign s         = s_reg;
    assign sb_out    = sbf_reg;

endmodule

// ----- hw/rtl/tlts_asin_step.sv -----
// tlts_asin_step: one bisection step of the arcsine search, 20 stages
// uses tlts_pkg and tlts_sine
`timescale 1ns / 1ps
module tlts_asin_step
    import tlts_pkg::*;
#(
    parameter int SB_W = 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [30:0]     lo,
    input  logic [30:0]     hi,
    input  logic [30:0]     u,
    input  logic [SB_W-1:0] sb_in,
    output logic            out_valid,
    output logic [30:0]     lo_out,
    output logic [30:0]     hi_out,
    output logic [30:0]     u_out,
    output logic [SB_W-1:0] sb_out
);

    localparam int INNER_W = 1 + 4 * 31 + SB_W;

    logic            v_reg, act_reg, ov_reg;
    logic [30:0]     mid_reg, lo_reg, hi_reg, u_reg;
    logic [SB_W-1:0] sb_reg, osb_reg;
    logic [30:0]     olo_reg, ohi_reg, ou_reg;

    logic [31:0]        mid_sum;
    logic [INNER_W-1:0] inner_in, inner_out;
    logic               sv;
    logic [30:0]        sq;

    logic            i_act;
    logic [30:0]     i_mid, i_lo, i_hi, i_u;
    logic [SB_W-1:0] i_sb;

    assign mid_sum = 32'(lo) + 32'(hi) + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= 1'b0;
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= in_valid;
            ov_reg <= sv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg <= mid_sum[31:1];
            act_reg <= lo < hi;
            lo_reg  <= lo;
            hi_reg  <= hi;
            u_reg   <= u;
            sb_reg  <= sb_in;
        end
    end

    assign inner_in = {act_reg, mid_reg, lo_reg, hi_reg, u_reg, sb_reg};

    tlts_sine #(
        .SB_W (INNER_W)
    ) u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg),
        .f         (mid_reg),
        .sb_in     (inner_in),
        .out_valid (sv),
        .s         (sq),
        .sb_out    (inner_out)
    );

    assign {i_act, i_mid, i_lo, i_hi, i_u, i_sb} = inner_out;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            olo_reg <= (i_act && sq <= i_u) ? i_mid : i_lo;
            ohi_reg <= (i_act && sq > i_u) ? i_mid - 31'd1 : i_hi;
            ou_reg  <= i_u;
            osb_reg <= i_sb;
        end
    end

    assign out_valid = ov_reg;
    assign lo_out    = olo_reg;
    assign hi_out    = ohi_reg;
    assign u_out     = ou_reg;
    assign sb_out    = osb_reg;

endmodule

// ----- hw/rtl/tidal_level_time_step.sv -----
// tidal_level_time_step: tide level and time to the next level step
// uses tlts_pkg, tlts_div, tlts_sine and tlts_asin_step
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_stall | start_time
//  rsp     | out | rsp_valid/rsp_stall | time_to_step, tide_level_now, error_code
//  cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one beat enters per cycle while req_stall is low; each beat passes through the
// phase divider, the level sine, the ratio divider and 31 arcsine bisection steps
// of 20 stages each
// reset clears all valid bits and loads the register defaults
// a held rsp beat freezes the whole pipeline; cfg_ready is always high
`timescale 1ns / 1ps
module tidal_level_time_step
    import tlts_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [31:0]        start_time,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [31:0]        time_to_step,
    output logic signed [24:0] tide_level_now,
    output logic [1:0]         error_code,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam logic [23:0] RANGE_RST  = 24'((64'd1 << FRAC_BITS));
    localparam logic [31:0] PERIOD_RST = 32'((64'd1 << FRAC_BITS));
    localparam logic [23:0] STEP_RST   = 24'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    logic [23:0] range_reg, step_reg;
    logic [31:0] period_reg;
    logic        en;

    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg  <= RANGE_RST;
            period_reg <= PERIOD_RST;
            step_reg   <= STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RANGE:  range_reg  <= cfg_data[23:0];
                CFG_PERIOD: period_reg <= cfg_data;
                CFG_STEP:   step_reg   <= cfg_data[23:0];
                default:    ;
            endcase
        end
    end

    // phase division
    item_t       req_item, div1_item;
    logic [32:0] quo1;
    logic        div1_v;

    assign req_item.err_period = (period_reg == 32'd0) || (start_time > period_reg);
    assign req_item.err_zero   = (range_reg == 24'd0) || (step_reg == 24'd0);
    assign req_item.t0         = start_time;

    tlts_div #(
        .W    (32),
        .QW   (33),
        .SB_W ($bits(item_t))
    ) u_div_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req_valid),
        .num       (start_time),
        .den       (period_reg),
        .sb_in     (req_item),
        .out_valid (div1_v),
        .quo       (quo1),
        .sb_out    (div1_item)
    );

    // quadrant fold
    logic [31:0] phase;
    logic [30:0] fr;
    logic        fold_v_reg;
    logic [30:0] fold_f_reg;
    fold_t       fold_reg;

    assign phase = quo1[31:0] - {2'b01, 30'd0};
    assign fr    = {1'b0, phase[29:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fold_v_reg <= 1'b0;
        else if (en)
            fold_v_reg <= div1_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fold_f_reg    <= phase[30] ? ONE_Q30 - fr : fr;
            fold_reg.neg  <= phase[31];
            fold_reg.item <= div1_item;
        end
    end

    logic        sin_v;
    logic [30:0] sin_s;
    logic [$bits(fold_t)-1:0] sin_sb;
    fold_t       sin_fold;

    tlts_sine #(
        .SB_W ($bits(fold_t))
    ) u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fold_v_reg),
        .f         (fold_f_reg),
        .sb_in     (fold_reg),
        .out_valid (sin_v),
        .s         (sin_s),
        .sb_out    (sin_sb)
    );

    assign sin_fold = fold_t'(sin_sb);

    // level, step direction and range check
    logic [63:0]        lvl_sum;
    logic [24:0]        mag;
    logic               z_v_reg, w_v_reg, b_v_reg;
    logic signed [24:0] z0_reg;
    item_t              z_item_reg, w_item_reg;
    logic signed [26:0] ztry_reg;
    logic               wan_reg;
    logic signed [24:0] wz0_reg;
    logic signed [26:0] ztry_abs, z0_abs, zsel;
    logic               over;
    logic [23:0]        absz_reg;
    lvl_t               b_lvl_reg;

    assign lvl_sum = 64'(range_reg) * 64'(sin_s) + 64'd536870912;
    assign mag     = lvl_sum[54:30];

    assign ztry_abs = (ztry_reg < 0) ? -ztry_reg : ztry_reg;
    assign z0_abs   = (wz0_reg < 0) ? -27'(wz0_reg) : 27'(wz0_reg);
    assign over     = ztry_abs > $signed({3'b000, range_reg});
    assign zsel     = over ? 27'(wz0_reg) : ztry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_v_reg <= 1'b0;
            w_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else if (en)
        begin
            z_v_reg <= sin_v;
            w_v_reg <= z_v_reg;
            b_v_reg <= w_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z0_reg     <= sin_fold.neg ? -$signed(mag) : $signed(mag);
            z_item_reg <= sin_fold.item;
            wan_reg    <= {z_item_reg.t0, 1'b0} > {1'b0, period_reg};
            ztry_reg   <= ({z_item_reg.t0, 1'b0} > {1'b0, period_reg})
                        ? 27'(z0_reg) - $signed({3'b000, step_reg})
                        : 27'(z0_reg) + $signed({3'b000, step_reg});
            wz0_reg    <= z0_reg;
            w_item_reg <= z_item_reg;
            absz_reg   <= over ? z0_abs[23:0] : ztry_abs[23:0];
            b_lvl_reg.zneg   <= zsel < 0;
            b_lvl_reg.waning <= wan_reg ^ over;
            b_lvl_reg.z0     <= wz0_reg;
            b_lvl_reg.item   <= w_item_reg;
        end
    end

    // level ratio division
    logic        div2_v;
    logic [30:0] quo2;
    logic [$bits(lvl_t)-1:0] div2_sb;

    tlts_div #(
        .W    (24),
        .QW   (31),
        .SB_W ($bits(lvl_t))
    ) u_div_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_v_reg),
        .num       (absz_reg),
        .den       (range_reg),
        .sb_in     (b_lvl_reg),
        .out_valid (div2_v),
        .quo       (quo2),
        .sb_out    (div2_sb)
    );

    // arcsine bisection chain
    logic                    ch_v  [0:ASIN_STEPS];
    logic [30:0]             ch_lo [0:ASIN_STEPS];
    logic [30:0]             ch_hi [0:ASIN_STEPS];
    logic [30:0]             ch_u  [0:ASIN_STEPS];
    logic [$bits(lvl_t)-1:0] ch_sb [0:ASIN_STEPS];

    assign ch_v[0]  = div2_v;
    assign ch_lo[0] = 31'd0;
    assign ch_hi[0] = ONE_Q30;
    assign ch_u[0]  = (quo2 > ONE_Q30) ? ONE_Q30 : quo2;
    assign ch_sb[0] = div2_sb;

    genvar k;
    generate
        for (k = 0; k < ASIN_STEPS; k++)
        begin : g_asin
            tlts_asin_step #(
                .SB_W ($bits(lvl_t))
            ) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (ch_v[k]),
                .lo        (ch_lo[k]),
                .hi        (ch_hi[k]),
                .u         (ch_u[k]),
                .sb_in     (ch_sb[k]),
                .out_valid (ch_v[k+1]),
                .lo_out    (ch_lo[k+1]),
                .hi_out    (ch_hi[k+1]),
                .u_out     (ch_u[k+1]),
                .sb_out    (ch_sb[k+1])
            );
        end
    endgenerate

    // target time and wrap
    lvl_t               a_lvl, t_lvl_reg, m_lvl_reg, n_lvl_reg, d_lvl_reg;
    logic               t_v_reg, m_v_reg, n_v_reg, d_v_reg, o_v_reg;
    logic [31:0]        w_reg;
    logic [32:0]        t1_reg;
    logic [31:0]        t1w_reg;
    logic [64:0]        t1_sum;
    logic [31:0]        t1c;
    logic signed [34:0] d0, d1, d1_reg, d2;
    logic [31:0]        tts_reg;
    logic signed [24:0] lvl_reg;
    logic [1:0]         code_reg;

    assign a_lvl  = lvl_t'(ch_sb[ASIN_STEPS]);
    assign t1_sum = 65'(64'(w_reg) * 64'(period_reg)) + 65'd2147483648;
    assign t1c    = (t1_reg > {1'b0, period_reg}) ? period_reg : t1_reg[31:0];
    assign d0     = $signed({3'b000, t1w_reg}) - $signed({3'b000, n_lvl_reg.item.t0});
    assign d1     = (d0 <= 0) ? d0 + $signed({3'b000, period_reg}) : d0;
    assign d2     = (d1_reg <= 0) ? d1_reg + $signed({3'b000, period_reg}) : d1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_v_reg <= 1'b0;
            m_v_reg <= 1'b0;
            n_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t_v_reg <= ch_v[ASIN_STEPS];
            m_v_reg <= t_v_reg;
            n_v_reg <= m_v_reg;
            d_v_reg <= n_v_reg;
            o_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= a_lvl.zneg ? 32'(ONE_Q30) - 32'(ch_lo[ASIN_STEPS])
                                    : 32'(ONE_Q30) + 32'(ch_lo[ASIN_STEPS]);
            t_lvl_reg <= a_lvl;
            t1_reg    <= t1_sum[64:32];
            m_lvl_reg <= t_lvl_reg;
            t1w_reg   <= m_lvl_reg.waning ? period_reg - t1c : t1c;
            n_lvl_reg <= m_lvl_reg;
            d1_reg    <= d1;
            d_lvl_reg <= n_lvl_reg;
            if (d_lvl_reg.item.err_period)
            begin
                tts_reg  <= 32'd0;
                lvl_reg  <= 25'sd0;
                code_reg <= ERR_PERIOD;
            end
            else if (d_lvl_reg.item.err_zero)
            begin
                tts_reg  <= 32'd0;
                lvl_reg  <= d_lvl_reg.z0;
                code_reg <= ERR_ZERO;
            end
            else
            begin
                tts_reg  <= d2[31:0];
                lvl_reg  <= d_lvl_reg.z0;
                code_reg <= ERR_OK;
            end
        end
    end

    assign rsp_valid      = o_v_reg;
    assign time_to_step   = tts_reg;
    assign tide_level_now = lvl_reg;
    assign error_code     = code_reg;

endmodule

// ----- hw/rtl/tlts_checker.sv -----
// tlts_checker: port-level assertions for tidal_level_time_step, bound to it
// uses tlts_pkg error codes
`timescale 1ns / 1ps
module tlts_checker
    import tlts_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [31:0]        time_to_step,
    input logic signed [24:0] tide_level_now,
    input logic [1:0]         error_code
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("rsp beat dropped while stalled");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |-> req_stall)
        else $error("req taken while rsp is held");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> error_code == ERR_OK || error_code == ERR_PERIOD
                      || error_code == ERR_ZERO)
        else $error("bad error code");

    a_period: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && error_code == ERR_PERIOD |-> time_to_step == 32'd0
                                                  && tide_level_now == 25'sd0)
        else $error("period error beat carries data");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && error_code == ERR_ZERO |-> time_to_step == 32'd0)
        else $error("zero range beat carries a time");

endmodule

bind tidal_level_time_step tlts_checker u_tlts_checker (.*);
